// ===== design/tpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types, constants and helpers for the touch press autorepeat block.
// ----------------------------------------------------------------------------
package tpa_pkg;

   localparam int ScreenWidthDefault  = 480;
   localparam int ScreenHeightDefault = 320;

   localparam int RawWidth      = 12;
   localparam int ProdWidth     = 2 * RawWidth;
   localparam int SpanWidth     = RawWidth + 1;
   localparam int TimeWidth     = 32;
   localparam int PageWidth     = 8;
   localparam int CoordWidth    = 16;
   localparam int DelayWidth    = 16;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 3;
   localparam int DivSteps      = ProdWidth;
   localparam int DivCntWidth   = $clog2(DivSteps);
   localparam int QueueDepth    = 2;

   localparam logic [CsrIndexWidth-1:0] RegSwapXy        = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegCalXLow       = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegCalXHigh      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegCalYLow       = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegCalYHigh      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegHoldDelayMs   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegRepeatPeriod  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegRepeatRadius  = 3'd7;

   typedef struct packed {
      logic [ProdWidth-1:0] prod;
      logic [RawWidth-1:0]  divisor;
      logic                 neg;
      logic                 zero;
   } tpa_axis_type;

   typedef struct packed {
      logic                 touched;
      logic [RawWidth-1:0]  raw_z;
      logic [TimeWidth-1:0] now_ms;
      logic [PageWidth-1:0] page_id;
      logic                 switching;
      tpa_axis_type         ax;
      tpa_axis_type         ay;
   } tpa_item_type;

   typedef struct packed {
      logic                swap_xy;
      logic [RawWidth-1:0] cal_x_low;
      logic [RawWidth-1:0] cal_x_high;
      logic [RawWidth-1:0] cal_y_low;
      logic [RawWidth-1:0] cal_y_high;
   } tpa_cal_type;

   typedef struct packed {
      logic [DelayWidth-1:0] hold_delay_ms;
      logic [DelayWidth-1:0] repeat_period_ms;
      logic [RawWidth-1:0]   repeat_radius;
   } tpa_rpt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SAT,
      ST_EMIT
   } tpa_state_type;

   // quotient magnitude plus sign to int16 with saturation; zero span gives 0
   function automatic logic signed [CoordWidth-1:0] saturate(
      input logic [ProdWidth-1:0] q,
      input logic                 neg,
      input logic                 zero
   );
      logic signed [CoordWidth-1:0] r;
      if (zero) begin
         r = '0;
      end else if (neg) begin
         if (q > ProdWidth'(32768)) begin
            r = 16'sh8000;
         end else begin
            r = CoordWidth'(~q[CoordWidth-1:0] + 16'd1);
         end
      end else begin
         if (q > ProdWidth'(32767)) begin
            r = 16'sh7FFF;
         end else begin
            r = q[CoordWidth-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ===== design/tpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_front
// Accepts samples, picks axes and forms the calibration products.
// ----------------------------------------------------------------------------
module tpa_front #(
   parameter int SCREEN_WIDTH  = tpa_pkg::ScreenWidthDefault,
   parameter int SCREEN_HEIGHT = tpa_pkg::ScreenHeightDefault
) (
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_touched,
   input  logic [tpa_pkg::RawWidth-1:0]       req_raw_x,
   input  logic [tpa_pkg::RawWidth-1:0]       req_raw_y,
   input  logic [tpa_pkg::RawWidth-1:0]       req_raw_z,
   input  logic [tpa_pkg::TimeWidth-1:0]      req_now_ms,
   input  logic [tpa_pkg::PageWidth-1:0]      req_page_id,
   input  logic                               req_switching,
   input  tpa_pkg::tpa_cal_type               cal,
   input  logic                               q_full,
   output logic                               q_push,
   output tpa_pkg::tpa_item_type              q_item
);

   localparam logic [tpa_pkg::RawWidth-1:0] LastX = tpa_pkg::RawWidth'(SCREEN_WIDTH - 1);
   localparam logic [tpa_pkg::RawWidth-1:0] LastY = tpa_pkg::RawWidth'(SCREEN_HEIGHT - 1);

   function automatic tpa_pkg::tpa_axis_type scale_prep(
      input logic [tpa_pkg::RawWidth-1:0] raw,
      input logic [tpa_pkg::RawWidth-1:0] lo,
      input logic [tpa_pkg::RawWidth-1:0] hi,
      input logic [tpa_pkg::RawWidth-1:0] last
   );
      logic [tpa_pkg::SpanWidth-1:0] num;
      logic [tpa_pkg::SpanWidth-1:0] span;
      logic [tpa_pkg::SpanWidth-1:0] num_n;
      logic [tpa_pkg::SpanWidth-1:0] span_n;
      logic [tpa_pkg::RawWidth-1:0]  num_mag;
      tpa_pkg::tpa_axis_type         a;
      num     = {1'b0, raw} - {1'b0, lo};
      span    = {1'b0, hi} - {1'b0, lo};
      num_n   = -num;
      span_n  = -span;
      num_mag = num[tpa_pkg::SpanWidth-1] ? num_n[tpa_pkg::RawWidth-1:0]
                                          : num[tpa_pkg::RawWidth-1:0];
      a.divisor = span[tpa_pkg::SpanWidth-1] ? span_n[tpa_pkg::RawWidth-1:0]
                                             : span[tpa_pkg::RawWidth-1:0];
      a.prod = {{tpa_pkg::RawWidth{1'b0}}, num_mag} * {{tpa_pkg::RawWidth{1'b0}}, last};
      a.neg  = num[tpa_pkg::SpanWidth-1] ^ span[tpa_pkg::SpanWidth-1];
      a.zero = (span == '0);
      return a;
   endfunction

   logic [tpa_pkg::RawWidth-1:0] raw_a;
   logic [tpa_pkg::RawWidth-1:0] raw_b;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign raw_a     = cal.swap_xy ? req_raw_y : req_raw_x;
   assign raw_b     = cal.swap_xy ? req_raw_x : req_raw_y;

   always_comb begin
      q_item.touched   = req_touched;
      q_item.raw_z     = req_raw_z;
      q_item.now_ms    = req_now_ms;
      q_item.page_id   = req_page_id;
      q_item.switching = req_switching;
      q_item.ax        = scale_prep(raw_a, cal.cal_x_low, cal.cal_x_high, LastX);
      q_item.ay        = scale_prep(raw_b, cal.cal_y_low, cal.cal_y_high, LastY);
   end

endmodule

// ===== design/tpa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_queue
// Short word queue between the front and back parts.
// ----------------------------------------------------------------------------
module tpa_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tpa_pkg::tpa_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output tpa_pkg::tpa_item_type pop_item
);

   localparam int PtrWidth = $clog2(tpa_pkg::QueueDepth);
   localparam int CntWidth = $clog2(tpa_pkg::QueueDepth + 1);

   tpa_pkg::tpa_item_type mem_ff [tpa_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == CntWidth'(tpa_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(tpa_pkg::QueueDepth - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(tpa_pkg::QueueDepth - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/tpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_back
// Serial division of both axes, press and repeat decision, result register.
// ----------------------------------------------------------------------------
module tpa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_not_empty,
   input  tpa_pkg::tpa_item_type               q_item,
   output logic                                q_pop,
   input  tpa_pkg::tpa_rpt_type                rpt,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_fire,
   output logic                                rsp_is_repeat,
   output logic signed [tpa_pkg::CoordWidth-1:0] rsp_press_x,
   output logic signed [tpa_pkg::CoordWidth-1:0] rsp_press_y,
   output logic [tpa_pkg::RawWidth-1:0]        rsp_press_z
);

   localparam int Pw = tpa_pkg::ProdWidth;
   localparam int Rw = tpa_pkg::RawWidth;
   localparam int Cw = tpa_pkg::CoordWidth;

   // one restoring division step: {remainder, shifted dividend/quotient}
   function automatic logic [Rw+Pw-1:0] div_step(
      input logic [Pw-1:0] dq,
      input logic [Rw-1:0] rem,
      input logic [Rw-1:0] dv
   );
      logic [Rw:0]   t;
      logic [Rw:0]   d;
      logic          ge;
      logic [Rw-1:0] r;
      t  = {rem, dq[Pw-1]};
      d  = t - {1'b0, dv};
      ge = (t >= {1'b0, dv});
      r  = ge ? d[Rw-1:0] : t[Rw-1:0];
      return {r, dq[Pw-2:0], ge};
   endfunction

   tpa_pkg::tpa_state_type       state_ff, state_in;
   tpa_pkg::tpa_item_type        item_ff, item_in;
   logic [Pw-1:0]                dq_x_ff, dq_x_in, dq_y_ff, dq_y_in;
   logic [Rw-1:0]                rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [tpa_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic signed [Cw-1:0]         px_ff, px_in, py_ff, py_in;

   logic                         was_down_ff, was_down_in;
   logic signed [Cw-1:0]         down_x_ff, down_x_in, down_y_ff, down_y_in;
   logic [tpa_pkg::TimeWidth-1:0] down_time_ff, down_time_in;
   logic [tpa_pkg::TimeWidth-1:0] last_fire_ff, last_fire_in;
   logic [tpa_pkg::PageWidth-1:0] down_page_ff, down_page_in;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_fire_ff, out_fire_in;
   logic                         out_rep_ff, out_rep_in;
   logic signed [Cw-1:0]         out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [Rw-1:0]                out_z_ff, out_z_in;

   logic [Rw+Pw-1:0]             step_x, step_y;
   logic [Cw:0]                  diff_x, diff_y, adiff_x, adiff_y;
   logic [tpa_pkg::TimeWidth-1:0] held, since_fire;
   logic                         rpt_ok;

   assign step_x     = div_step(dq_x_ff, rem_x_ff, item_ff.ax.divisor);
   assign step_y     = div_step(dq_y_ff, rem_y_ff, item_ff.ay.divisor);
   assign diff_x     = {px_ff[Cw-1], px_ff} - {down_x_ff[Cw-1], down_x_ff};
   assign diff_y     = {py_ff[Cw-1], py_ff} - {down_y_ff[Cw-1], down_y_ff};
   assign adiff_x    = diff_x[Cw] ? -diff_x : diff_x;
   assign adiff_y    = diff_y[Cw] ? -diff_y : diff_y;
   assign held       = item_ff.now_ms - down_time_ff;
   assign since_fire = item_ff.now_ms - last_fire_ff;
   assign rpt_ok     = (held >= {16'd0, rpt.hold_delay_ms})
                    && (since_fire >= {16'd0, rpt.repeat_period_ms})
                    && (adiff_x <= {5'd0, rpt.repeat_radius})
                    && (adiff_y <= {5'd0, rpt.repeat_radius});

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      dq_x_in      = dq_x_ff;
      dq_y_in      = dq_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      cnt_in       = cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      was_down_in  = was_down_ff;
      down_x_in    = down_x_ff;
      down_y_in    = down_y_ff;
      down_time_in = down_time_ff;
      last_fire_in = last_fire_ff;
      down_page_in = down_page_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_fire_in  = out_fire_ff;
      out_rep_in   = out_rep_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      q_pop        = 1'b0;
      case (state_ff)
         tpa_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               dq_x_in  = q_item.ax.prod;
               dq_y_in  = q_item.ay.prod;
               rem_x_in = '0;
               rem_y_in = '0;
               cnt_in   = '0;
               state_in = tpa_pkg::ST_DIV;
            end
         end
         tpa_pkg::ST_DIV: begin
            {rem_x_in, dq_x_in} = step_x;
            {rem_y_in, dq_y_in} = step_y;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tpa_pkg::DivCntWidth'(tpa_pkg::DivSteps - 1)) begin
               state_in = tpa_pkg::ST_SAT;
            end
         end
         tpa_pkg::ST_SAT: begin
            px_in    = tpa_pkg::saturate(dq_x_ff, item_ff.ax.neg, item_ff.ax.zero);
            py_in    = tpa_pkg::saturate(dq_y_ff, item_ff.ay.neg, item_ff.ay.zero);
            state_in = tpa_pkg::ST_EMIT;
         end
         tpa_pkg::ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_fire_in  = 1'b0;
               out_rep_in   = 1'b0;
               out_x_in     = '0;
               out_y_in     = '0;
               out_z_in     = '0;
               if (item_ff.touched) begin
                  if (!was_down_ff) begin
                     down_x_in    = px_ff;
                     down_y_in    = py_ff;
                     down_time_in = item_ff.now_ms;
                     last_fire_in = item_ff.now_ms;
                     down_page_in = item_ff.page_id;
                     if (!item_ff.switching) begin
                        out_fire_in = 1'b1;
                        out_x_in    = px_ff;
                        out_y_in    = py_ff;
                        out_z_in    = item_ff.raw_z;
                     end
                  end else if (!item_ff.switching && item_ff.page_id == down_page_ff
                               && rpt_ok) begin
                     last_fire_in = item_ff.now_ms;
                     out_fire_in  = 1'b1;
                     out_rep_in   = 1'b1;
                     out_x_in     = down_x_ff;
                     out_y_in     = down_y_ff;
                  end
               end
               was_down_in = item_ff.touched;
               state_in    = tpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpa_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         was_down_ff  <= 1'b0;
         down_x_ff    <= '0;
         down_y_ff    <= '0;
         down_time_ff <= '0;
         last_fire_ff <= '0;
         down_page_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         was_down_ff  <= was_down_in;
         down_x_ff    <= down_x_in;
         down_y_ff    <= down_y_in;
         down_time_ff <= down_time_in;
         last_fire_ff <= last_fire_in;
         down_page_ff <= down_page_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dq_x_ff     <= dq_x_in;
      dq_y_ff     <= dq_y_in;
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      cnt_ff      <= cnt_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      out_fire_ff <= out_fire_in;
      out_rep_ff  <= out_rep_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_fire      = out_fire_ff;
   assign rsp_is_repeat = out_rep_ff;
   assign rsp_press_x   = out_x_ff;
   assign rsp_press_y   = out_y_ff;
   assign rsp_press_z   = out_z_ff;

endmodule

// ===== design/touch_press_edge_autorepeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_edge_autorepeat
// Touch sample to press events with edge detect and hold auto-repeat.
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_ready | one touch sample
//   rsp_    | out       | rsp_valid/rsp_ready | one press result per sample
//   csr_    | in        | csr_we              | register index and data
//
// A sample enters the two-word queue the cycle it is accepted. The back part
// takes one word at a time: pop, 24 restoring divide steps (one divider per
// axis, both running in parallel), saturate, then decide and load the result
// register once it is free or being read out; only then is the next word popped.
// Synchronous reset clears control and press history, sets register defaults.
// Either side may stall; the queue and result register decouple them.
// ----------------------------------------------------------------------------
module touch_press_edge_autorepeat #(
   parameter int SCREEN_WIDTH  = tpa_pkg::ScreenWidthDefault,
   parameter int SCREEN_HEIGHT = tpa_pkg::ScreenHeightDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_touched,
   input  logic [tpa_pkg::RawWidth-1:0]            req_raw_x,
   input  logic [tpa_pkg::RawWidth-1:0]            req_raw_y,
   input  logic [tpa_pkg::RawWidth-1:0]            req_raw_z,
   input  logic [tpa_pkg::TimeWidth-1:0]           req_now_ms,
   input  logic [tpa_pkg::PageWidth-1:0]           req_page_id,
   input  logic                                    req_switching,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_fire,
   output logic                                    rsp_is_repeat,
   output logic signed [tpa_pkg::CoordWidth-1:0]   rsp_press_x,
   output logic signed [tpa_pkg::CoordWidth-1:0]   rsp_press_y,
   output logic [tpa_pkg::RawWidth-1:0]            rsp_press_z,
   input  logic                                    csr_we,
   input  logic [tpa_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [tpa_pkg::CsrDataWidth-1:0]        csr_wdata
);

   tpa_pkg::tpa_cal_type  cal_ff, cal_in;
   tpa_pkg::tpa_rpt_type  rpt_ff, rpt_in;
   tpa_pkg::tpa_item_type push_item;
   tpa_pkg::tpa_item_type pop_item;
   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_not_empty;

   always_comb begin
      cal_in = cal_ff;
      rpt_in = rpt_ff;
      if (csr_we) begin
         case (csr_index)
            tpa_pkg::RegSwapXy:       cal_in.swap_xy          = csr_wdata[0];
            tpa_pkg::RegCalXLow:      cal_in.cal_x_low        = csr_wdata[11:0];
            tpa_pkg::RegCalXHigh:     cal_in.cal_x_high       = csr_wdata[11:0];
            tpa_pkg::RegCalYLow:      cal_in.cal_y_low        = csr_wdata[11:0];
            tpa_pkg::RegCalYHigh:     cal_in.cal_y_high       = csr_wdata[11:0];
            tpa_pkg::RegHoldDelayMs:  rpt_in.hold_delay_ms    = csr_wdata;
            tpa_pkg::RegRepeatPeriod: rpt_in.repeat_period_ms = csr_wdata;
            tpa_pkg::RegRepeatRadius: rpt_in.repeat_radius    = csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.swap_xy          <= 1'b0;
         cal_ff.cal_x_low        <= 12'd0;
         cal_ff.cal_x_high       <= 12'd4095;
         cal_ff.cal_y_low        <= 12'd0;
         cal_ff.cal_y_high       <= 12'd4095;
         rpt_ff.hold_delay_ms    <= 16'd500;
         rpt_ff.repeat_period_ms <= 16'd150;
         rpt_ff.repeat_radius    <= 12'd20;
      end else begin
         cal_ff <= cal_in;
         rpt_ff <= rpt_in;
      end
   end

   tpa_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_touched   (req_touched),
      .req_raw_x     (req_raw_x),
      .req_raw_y     (req_raw_y),
      .req_raw_z     (req_raw_z),
      .req_now_ms    (req_now_ms),
      .req_page_id   (req_page_id),
      .req_switching (req_switching),
      .cal           (cal_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   tpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (pop_item)
   );

   tpa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rpt           (rpt_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_fire      (rsp_fire),
      .rsp_is_repeat (rsp_is_repeat),
      .rsp_press_x   (rsp_press_x),
      .rsp_press_y   (rsp_press_y),
      .rsp_press_z   (rsp_press_z)
   );

   a_no_fire_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fire |-> !rsp_is_repeat && rsp_press_x == '0
                                 && rsp_press_y == '0 && rsp_press_z == '0)
      else $error("non-firing word carries payload");

   a_repeat_no_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_repeat |-> rsp_fire && rsp_press_z == '0)
      else $error("repeat word with pressure or without fire");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_not_empty)
      else $error("result or queue word present after reset");

endmodule

// ===== verif/tb_touch_press_edge_autorepeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_press_edge_autorepeat
// Self-checking bench for the touch press detector with hold auto-repeat.
//
// A short table of touch samples covers the corner cases first: calibration
// extremes, a zero span, a reversed span, saturation, an edge during a page
// switch, a page change and time wrap. Rows with an obvious answer carry it
// inline; the rest are checked against the bench's own press predictor.
// Random phases follow. Each phase loads a fresh register set while the
// block is idle, then sends mostly press-hold-release gestures with jitter
// and some raw noise. Both handshakes idle at random. The response side also
// holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_touch_press_edge_autorepeat;

   localparam int Rw          = tpa_pkg::RawWidth;
   localparam int Tw          = tpa_pkg::TimeWidth;
   localparam int Gw          = tpa_pkg::PageWidth;
   localparam int Cw          = tpa_pkg::CoordWidth;
   localparam int Dw          = tpa_pkg::DelayWidth;
   localparam int Iw          = tpa_pkg::CsrIndexWidth;
   localparam int Ww          = tpa_pkg::CsrDataWidth;
   localparam int LastCol     = tpa_pkg::ScreenWidthDefault - 1;
   localparam int LastRow     = tpa_pkg::ScreenHeightDefault - 1;
   localparam int CycleLimit  = 600000;
   localparam int Phases      = 12;
   localparam int PhaseItems  = 110;
   localparam int StallCycles = 300;

   typedef struct packed {
      logic          touched;
      logic [Rw-1:0] raw_x;
      logic [Rw-1:0] raw_y;
      logic [Rw-1:0] raw_z;
      logic [Tw-1:0] now_ms;
      logic [Gw-1:0] page_id;
      logic          switching;
   } sample_type;

   typedef struct packed {
      logic                 fire;
      logic                 is_repeat;
      logic signed [Cw-1:0] x;
      logic signed [Cw-1:0] y;
      logic [Rw-1:0]        z;
   } press_type;

   typedef struct packed {
      logic          swap_xy;
      logic [Rw-1:0] x_lo;
      logic [Rw-1:0] x_hi;
      logic [Rw-1:0] y_lo;
      logic [Rw-1:0] y_hi;
      logic [Dw-1:0] hold;
      logic [Dw-1:0] period;
      logic [Rw-1:0] radius;
   } cal_set_type;

   typedef struct packed {
      logic        is_cfg;
      cal_set_type cal;
      sample_type  smp;
      logic        typed;
      press_type   want;
   } row_type;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_touched   = 1'b0;
   logic [Rw-1:0]        req_raw_x     = '0;
   logic [Rw-1:0]        req_raw_y     = '0;
   logic [Rw-1:0]        req_raw_z     = '0;
   logic [Tw-1:0]        req_now_ms    = '0;
   logic [Gw-1:0]        req_page_id   = '0;
   logic                 req_switching = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic                 rsp_fire;
   logic                 rsp_is_repeat;
   logic signed [Cw-1:0] rsp_press_x;
   logic signed [Cw-1:0] rsp_press_y;
   logic [Rw-1:0]        rsp_press_z;
   logic                 csr_we        = 1'b0;
   logic [Iw-1:0]        csr_index     = '0;
   logic [Ww-1:0]        csr_wdata     = '0;

   // predictor state
   cal_set_type          cal_cur;
   logic                 held       = 1'b0;
   logic signed [Cw-1:0] held_x     = '0;
   logic signed [Cw-1:0] held_y     = '0;
   logic [Tw-1:0]        held_time  = '0;
   logic [Tw-1:0]        fired_time = '0;
   logic [Gw-1:0]        held_page  = '0;

   press_type press_due_q[$];
   row_type   rows[$];
   logic      drv_typed  = 1'b0;
   press_type drv_want   = '0;
   logic      quiet      = 1'b0;
   logic      stall_req  = 1'b0;
   int        errors     = 0;
   int        items_sent = 0;

   touch_press_edge_autorepeat #(
      .SCREEN_WIDTH (tpa_pkg::ScreenWidthDefault),
      .SCREEN_HEIGHT(tpa_pkg::ScreenHeightDefault)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_touched  (req_touched),
      .req_raw_x    (req_raw_x),
      .req_raw_y    (req_raw_y),
      .req_raw_z    (req_raw_z),
      .req_now_ms   (req_now_ms),
      .req_page_id  (req_page_id),
      .req_switching(req_switching),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_fire     (rsp_fire),
      .rsp_is_repeat(rsp_is_repeat),
      .rsp_press_x  (rsp_press_x),
      .rsp_press_y  (rsp_press_y),
      .rsp_press_z  (rsp_press_z),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic cal_set_type cal_make(input int sw, input int xl, input int xh,
                                            input int yl, input int yh, input int hd,
                                            input int rp, input int rr);
      cal_set_type c;
      c.swap_xy = sw[0];
      c.x_lo    = Rw'(xl);
      c.x_hi    = Rw'(xh);
      c.y_lo    = Rw'(yl);
      c.y_hi    = Rw'(yh);
      c.hold    = Dw'(hd);
      c.period  = Dw'(rp);
      c.radius  = Rw'(rr);
      return c;
   endfunction

   function automatic sample_type sample_make(input int t, input int rx, input int ry,
                                              input int rz, input logic [31:0] now,
                                              input int pg, input int sw);
      sample_type s;
      s.touched   = t[0];
      s.raw_x     = Rw'(rx);
      s.raw_y     = Rw'(ry);
      s.raw_z     = Rw'(rz);
      s.now_ms    = now;
      s.page_id   = Gw'(pg);
      s.switching = sw[0];
      return s;
   endfunction

   function automatic press_type press_make(input int f, input int r, input int x,
                                            input int y, input int z);
      press_type p;
      p.fire      = f[0];
      p.is_repeat = r[0];
      p.x         = Cw'(x);
      p.y         = Cw'(y);
      p.z         = Rw'(z);
      return p;
   endfunction

   function automatic logic signed [Cw-1:0] cal_scale(
      input logic [Rw-1:0] raw,
      input logic [Rw-1:0] lo,
      input logic [Rw-1:0] hi,
      input int            last
   );
      longint span;
      longint v;
      span = longint'(hi) - longint'(lo);
      if (span == 0) begin
         return '0;
      end
      v = (longint'(raw) - longint'(lo)) * longint'(last) / span;
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return Cw'(v);
   endfunction

   function automatic press_type press_predict(input sample_type s);
      press_type            p;
      logic signed [Cw-1:0] px;
      logic signed [Cw-1:0] py;
      logic [Tw-1:0]        since_down;
      logic [Tw-1:0]        since_fire;
      int                   dx;
      int                   dy;
      p = '0;
      if (s.touched) begin
         if (cal_cur.swap_xy) begin
            px = cal_scale(s.raw_y, cal_cur.x_lo, cal_cur.x_hi, LastCol);
            py = cal_scale(s.raw_x, cal_cur.y_lo, cal_cur.y_hi, LastRow);
         end else begin
            px = cal_scale(s.raw_x, cal_cur.x_lo, cal_cur.x_hi, LastCol);
            py = cal_scale(s.raw_y, cal_cur.y_lo, cal_cur.y_hi, LastRow);
         end
         if (!held) begin
            held_x     = px;
            held_y     = py;
            held_time  = s.now_ms;
            fired_time = s.now_ms;
            held_page  = s.page_id;
            if (!s.switching) begin
               p.fire = 1'b1;
               p.x    = px;
               p.y    = py;
               p.z    = s.raw_z;
            end
         end else if (!s.switching && s.page_id == held_page) begin
            since_down = s.now_ms - held_time;
            since_fire = s.now_ms - fired_time;
            dx = int'(px) - int'(held_x);
            dy = int'(py) - int'(held_y);
            if (dx < 0) begin
               dx = -dx;
            end
            if (dy < 0) begin
               dy = -dy;
            end
            if (since_down >= Tw'(cal_cur.hold) &&
                since_fire >= Tw'(cal_cur.period) &&
                dx <= int'(cal_cur.radius) && dy <= int'(cal_cur.radius)) begin
               fired_time  = s.now_ms;
               p.fire      = 1'b1;
               p.is_repeat = 1'b1;
               p.x         = held_x;
               p.y         = held_y;
            end
         end
      end
      held = s.touched;
      return p;
   endfunction

   function automatic void field_check(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         errors++;
         $display("%0t %s: expected %0d, got %0d", $time, name, want_v, got_v);
      end
   endfunction

   function automatic logic [Rw-1:0] raw_jitter(input int base, input int j);
      int v;
      v = base + int'($urandom_range(0, 2 * j)) - j;
      if (v < 0) begin
         v = 0;
      end
      if (v > 4095) begin
         v = 4095;
      end
      return Rw'(v);
   endfunction

   function automatic cal_set_type cal_pick(input int ph);
      cal_set_type c;
      int          t;
      if (ph == 0) begin
         return cal_make(1, 4095, 4095, 4095, 4095, 65535, 65535, 4095);
      end
      if (ph == 1) begin
         return cal_make(0, 0, 0, 0, 0, 0, 0, 0);
      end
      c.swap_xy = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
         c.x_lo   = Rw'($urandom);
         c.x_hi   = Rw'($urandom);
         c.y_lo   = Rw'($urandom);
         c.y_hi   = Rw'($urandom);
         c.hold   = Dw'($urandom);
         c.period = Dw'($urandom);
         c.radius = Rw'($urandom);
         return c;
      end
      c.x_lo = Rw'($urandom_range(0, 500));
      c.x_hi = Rw'($urandom_range(3500, 4095));
      c.y_lo = Rw'($urandom_range(0, 500));
      c.y_hi = Rw'($urandom_range(3500, 4095));
      if ($urandom_range(0, 3) == 0) begin
         t = int'(c.x_lo);
         c.x_lo = c.x_hi;
         c.x_hi = Rw'(t);
      end
      if ($urandom_range(0, 3) == 0) begin
         t = int'(c.y_lo);
         c.y_lo = c.y_hi;
         c.y_hi = Rw'(t);
      end
      if ($urandom_range(0, 9) == 0) begin
         c.y_hi = c.y_lo;
      end
      c.hold   = Dw'($urandom_range(0, 400));
      c.period = Dw'($urandom_range(0, 200));
      c.radius = ($urandom_range(0, 5) == 0) ? Rw'(4095)
                                            : Rw'($urandom_range(0, 60));
      return c;
   endfunction

   task automatic add_smp(input sample_type s);
      rows.push_back({1'b0, cal_set_type'(0), s, 1'b0, press_type'(0)});
   endtask

   task automatic add_chk(input sample_type s, input press_type w);
      rows.push_back({1'b0, cal_set_type'(0), s, 1'b1, w});
   endtask

   task automatic add_cfg(input cal_set_type c);
      rows.push_back({1'b1, c, sample_type'(0), 1'b0, press_type'(0)});
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_sample(input sample_type s, input logic typed, input press_type w);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_touched   <= s.touched;
      req_raw_x     <= s.raw_x;
      req_raw_y     <= s.raw_y;
      req_raw_z     <= s.raw_z;
      req_now_ms    <= s.now_ms;
      req_page_id   <= s.page_id;
      req_switching <= s.switching;
      drv_typed = typed;
      drv_want  = w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic csr_put(input logic [Iw-1:0] idx, input logic [Ww-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // registers change only with the pipe drained
   task automatic apply_config(input cal_set_type c);
      req_valid <= 1'b0;
      while (press_due_q.size() != 0) @(negedge clock);
      csr_put(tpa_pkg::RegSwapXy, Ww'(c.swap_xy));
      csr_put(tpa_pkg::RegCalXLow, Ww'(c.x_lo));
      csr_put(tpa_pkg::RegCalXHigh, Ww'(c.x_hi));
      csr_put(tpa_pkg::RegCalYLow, Ww'(c.y_lo));
      csr_put(tpa_pkg::RegCalYHigh, Ww'(c.y_hi));
      csr_put(tpa_pkg::RegHoldDelayMs, Ww'(c.hold));
      csr_put(tpa_pkg::RegRepeatPeriod, Ww'(c.period));
      csr_put(tpa_pkg::RegRepeatRadius, Ww'(c.radius));
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      press_type got;
      press_type w;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               tpa_pkg::RegSwapXy:       cal_cur.swap_xy = csr_wdata[0];
               tpa_pkg::RegCalXLow:      cal_cur.x_lo    = csr_wdata[Rw-1:0];
               tpa_pkg::RegCalXHigh:     cal_cur.x_hi    = csr_wdata[Rw-1:0];
               tpa_pkg::RegCalYLow:      cal_cur.y_lo    = csr_wdata[Rw-1:0];
               tpa_pkg::RegCalYHigh:     cal_cur.y_hi    = csr_wdata[Rw-1:0];
               tpa_pkg::RegHoldDelayMs:  cal_cur.hold    = csr_wdata[Dw-1:0];
               tpa_pkg::RegRepeatPeriod: cal_cur.period  = csr_wdata[Dw-1:0];
               tpa_pkg::RegRepeatRadius: cal_cur.radius  = csr_wdata[Rw-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.fire      = rsp_fire;
            got.is_repeat = rsp_is_repeat;
            got.x         = rsp_press_x;
            got.y         = rsp_press_y;
            got.z         = rsp_press_z;
            if (press_due_q.size() == 0) begin
               errors++;
               $display("%0t unexpected word: fire %0d rep %0d x %0d y %0d z %0d",
                        $time, got.fire, got.is_repeat, got.x, got.y, got.z);
            end else begin
               w = press_due_q.pop_front();
               field_check("fire", int'(w.fire), int'(got.fire));
               field_check("is_repeat", int'(w.is_repeat), int'(got.is_repeat));
               field_check("press_x", int'(w.x), int'(got.x));
               field_check("press_y", int'(w.y), int'(got.y));
               field_check("press_z", int'(w.z), int'(got.z));
            end
         end
         if (req_valid && req_ready) begin
            w = press_predict({req_touched, req_raw_x, req_raw_y, req_raw_z,
                               req_now_ms, req_page_id, req_switching});
            press_due_q.push_back(drv_typed ? drv_want : w);
         end
      end
   end

   initial begin
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_req) begin
            stall_req = 1'b0;
            w = StallCycles;
         end else begin
            w = quiet ? 0 : $urandom_range(0, 11);
         end
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("tb_touch_press_edge_autorepeat: errors");
      $finish;
   end

   initial begin
      sample_type  s;
      logic [31:0] t_ms;
      logic [7:0]  pg;
      int          bx;
      int          by;
      int          jit;
      int          len;
      int          target;
      press_type   none;
      none    = '0;
      cal_cur = cal_make(0, 0, 4095, 0, 4095, 500, 150, 20);

      // reset register values
      add_chk(sample_make(1, 0, 0, 4095, 1000, 5, 0), press_make(1, 0, 0, 0, 4095));
      add_chk(sample_make(1, 0, 0, 0, 1200, 5, 0), none);
      add_chk(sample_make(1, 0, 0, 7, 1500, 5, 0), press_make(1, 1, 0, 0, 0));
      add_chk(sample_make(0, 4095, 4095, 4095, 1600, 5, 1), none);
      add_chk(sample_make(1, 4095, 4095, 2048, 2000, 255, 0),
              press_make(1, 0, 479, 319, 2048));
      add_smp(sample_make(1, 4090, 4095, 1, 3000, 254, 0));
      add_smp(sample_make(1, 4090, 4095, 1, 3200, 255, 0));
      add_chk(sample_make(0, 0, 0, 0, 3300, 255, 0), none);
      add_chk(sample_make(1, 2000, 1000, 300, 4000, 9, 1), none);
      add_smp(sample_make(1, 2000, 1000, 300, 5000, 9, 0));
      add_chk(sample_make(0, 0, 0, 0, 5100, 0, 0), none);
      add_smp(sample_make(1, 100, 200, 300, 32'hFFFF_FF00, 77, 0));
      add_smp(sample_make(1, 100, 200, 0, 32'h0000_0300, 77, 0));
      // swapped, saturating x, reversed y, repeats unconditional
      add_cfg(cal_make(1, 0, 1, 4095, 0, 0, 0, 4095));
      add_chk(sample_make(0, 0, 0, 0, 5900, 3, 0), none);
      add_smp(sample_make(1, 4095, 4095, 4095, 6000, 3, 0));
      add_smp(sample_make(1, 2000, 4095, 0, 6000, 3, 0));
      // x saturates low, zero y span, longest timing
      add_cfg(cal_make(0, 4094, 4095, 7, 7, 65535, 65535, 0));
      add_chk(sample_make(0, 0, 0, 0, 7000, 3, 0), none);
      add_chk(sample_make(1, 0, 123, 100, 10000, 3, 0), press_make(1, 0, -32768, 0, 100));
      add_chk(sample_make(1, 0, 4000, 0, 75535, 3, 0), press_make(1, 1, -32768, 0, 0));
      add_chk(sample_make(1, 0, 0, 0, 75536, 3, 0), none);
      add_chk(sample_make(0, 0, 0, 0, 75600, 3, 0), none);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         quiet = (i >= 18);
         if (rows[i].is_cfg) begin
            apply_config(rows[i].cal);
         end else begin
            send_sample(rows[i].smp, rows[i].typed, rows[i].want);
         end
      end

      t_ms = $urandom;
      for (int ph = 0; ph < Phases; ph++) begin
         quiet = 1'b0;
         apply_config(cal_pick(ph));
         if (ph == 2) begin
            stall_req = 1'b1;
         end
         target = items_sent + PhaseItems;
         while (items_sent < target) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
               s.touched   = 1'($urandom_range(0, 1));
               s.raw_x     = Rw'($urandom);
               s.raw_y     = Rw'($urandom);
               s.raw_z     = Rw'($urandom);
               s.now_ms    = $urandom;
               s.page_id   = Gw'($urandom);
               s.switching = 1'($urandom_range(0, 1));
               send_sample(s, 1'b0, none);
            end else begin
               bx  = $urandom_range(0, 4095);
               by  = $urandom_range(0, 4095);
               jit = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 120);
               pg  = Gw'($urandom);
               len = $urandom_range(1, 30);
               if ($urandom_range(0, 19) == 0) begin
                  t_ms = $urandom;
               end
               for (int k = 0; k < len; k++) begin
                  t_ms = t_ms + $urandom_range(0, 100);
                  if ($urandom_range(0, 24) == 0) begin
                     pg = pg + 8'd1;
                  end
                  s.touched   = 1'b1;
                  s.raw_x     = raw_jitter(bx, jit);
                  s.raw_y     = raw_jitter(by, jit);
                  s.raw_z     = Rw'($urandom);
                  s.now_ms    = t_ms;
                  s.page_id   = pg;
                  s.switching = (k == 0) ? ($urandom_range(0, 7) == 0)
                                         : ($urandom_range(0, 29) == 0);
                  send_sample(s, 1'b0, none);
               end
               if ($urandom_range(0, 7) != 0) begin
                  t_ms = t_ms + $urandom_range(0, 300);
                  s.touched   = 1'b0;
                  s.raw_x     = Rw'($urandom);
                  s.raw_y     = Rw'($urandom);
                  s.raw_z     = Rw'($urandom);
                  s.now_ms    = t_ms;
                  s.switching = 1'($urandom_range(0, 1));
                  send_sample(s, 1'b0, none);
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (press_due_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (errors == 0) begin
         $display("tb_touch_press_edge_autorepeat: clean");
      end else begin
         $display("tb_touch_press_edge_autorepeat: errors");
      end
      $finish;
   end

endmodule
